FILE: rtl/core/brct_pkg.sv
// Shared types and constants for the baseline removal and cosine taper block.
`default_nettype none
package brct_pkg;

  // Field and datapath widths.
  localparam int unsigned SampleW   = 24;
  localparam int unsigned SumW      = 37;
  localparam int unsigned DiffW     = 26;
  localparam int unsigned WinW      = 13;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned FactW     = 17;
  localparam int unsigned MeanNumW  = 36;
  localparam int unsigned PhaseNumW = 29;
  localparam int unsigned QW        = 31;
  localparam int unsigned MulW      = 62;

  // Taper factor of one in Q1.16.
  localparam logic [FactW-1:0] FactOne = 17'd65536;
  localparam logic [QW-1:0]    QOne    = 31'd1073741824;

  // Sine polynomial coefficients in Q30.
  localparam logic [QW-1:0] CoefC1 = 31'd1686629713;
  localparam logic [QW-1:0] CoefC3 = 31'd693598668;
  localparam logic [QW-1:0] CoefC5 = 31'd85569305;
  localparam logic [QW-1:0] CoefC7 = 31'd5026995;
  localparam logic [QW-1:0] CoefC9 = 31'd172272;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_DRAIN  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DIFF,
    ST_MUL,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_DIV,
    T_X2,
    T_H7,
    T_H5,
    T_H3,
    T_H1,
    T_S,
    T_F
  } taper_state_e;

  // Per-transaction controls sent from the sequencer to every lane.
  typedef struct packed {
    logic wr_en;
    logic clear;
    logic acc_en;
    logic rd_en;
    logic mean_start;
    logic diff_en;
    logic mul_en;
    logic apply;
  } lane_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/baseline_removal_cosine_taper_3ch.sv
// Top level: record sequencer, three channel lanes, taper unit and output register.
//
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+--------------------------
//  command  | mode_i, radial_in_i, transverse_in_i,     | start_i high, busy_o low
//           | third_in_i                                |
//  result   | radial_out_o, transverse_out_o,           | result_valid_o, one cycle
//           | third_out_o, sample_index_o, last_flag_o  |
//  config   | cfg_data_i                                | cfg_valid_i && cfg_ready_o
//
// Start and append commands finish in the accepting cycle; busy_o stays low.
// A drain holds busy_o through the wait, difference, product and emit steps; when the
// taper applies, the wait also covers the taper: the 29-step phase divider, a hand-over
// step and 7 multiplier steps. The 36-step mean divider on the first sample runs under
// the taper and adds nothing.
// The result strobe comes in the first cycle with busy_o low; the receiver cannot stall it.
// Reset clears control state, sums and the configured window length.
`default_nettype none
module baseline_removal_cosine_taper_3ch #(
  parameter int unsigned RECORD_DEPTH = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic signed [brct_pkg::SampleW-1:0] radial_in_i,
  input  wire logic signed [brct_pkg::SampleW-1:0] transverse_in_i,
  input  wire logic signed [brct_pkg::SampleW-1:0] third_in_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [brct_pkg::WinW-1:0]           cfg_data_i,
  output logic                                     result_valid_o,
  output logic signed [brct_pkg::SampleW-1:0]      radial_out_o,
  output logic signed [brct_pkg::SampleW-1:0]      transverse_out_o,
  output logic signed [brct_pkg::SampleW-1:0]      third_out_o,
  output logic [brct_pkg::IdxW-1:0]                sample_index_o,
  output logic                                     last_flag_o
);

  localparam int unsigned AW  = $clog2(RECORD_DEPTH);
  localparam int unsigned CW  = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned XW  = (CW > brct_pkg::WinW) ? CW : brct_pkg::WinW;
  localparam int unsigned NL  = 3;
  localparam int unsigned SW  = brct_pkg::SampleW;

  brct_pkg::ctrl_state_e state_q, state_d;
  brct_pkg::lane_ctrl_t  ctrl;

  logic [brct_pkg::WinW-1:0] wl_q;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             pos_q, pos_d;
  logic [CW-1:0]             j_q;
  logic                      last_q, apply_q, taper_q;
  logic                      apply_d, taper_d, last_d;
  logic                      accept;
  logic [brct_pkg::WinW-1:0] w_now;
  logic [AW-1:0]             wr_addr;
  logic                      taper_start;
  logic                      taper_busy;
  logic [brct_pkg::FactW-1:0] taper_f, lane_f;
  logic [NL-1:0]             lane_busy;
  logic signed [SW-1:0]      samples [NL];
  logic signed [SW-1:0]      results [NL];
  logic [31:0]               pos_wide, j_wide;
  logic                      valid_q;
  logic signed [SW-1:0]      out_q [NL];
  logic [brct_pkg::IdxW-1:0] idx_q;
  logic                      out_last_q;

  assign samples[0] = radial_in_i;
  assign samples[1] = transverse_in_i;
  assign samples[2] = third_in_i;

  assign accept      = start_i && (state_q == brct_pkg::ST_IDLE);
  assign busy_o      = (state_q != brct_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Effective window: the configured length clamped to the record length.
  assign w_now    = (XW'(wl_q) < XW'(count_q)) ? wl_q : brct_pkg::WinW'(count_q);
  assign pos_wide = 32'(pos_q);
  assign j_wide   = 32'(j_q);
  assign lane_f   = taper_q ? taper_f : brct_pkg::FactOne;

  // Command decode, sequencing and lane controls.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    apply_d     = apply_q;
    taper_d     = taper_q;
    last_d      = last_q;
    wr_addr     = count_q[AW-1:0];
    taper_start = 1'b0;
    ctrl        = '0;
    ctrl.apply  = apply_q;
    case (state_q)
      brct_pkg::ST_IDLE: begin
        if (accept) begin
          case (brct_pkg::mode_e'(mode_i))
            brct_pkg::MODE_START: begin
              ctrl.wr_en  = 1'b1;
              ctrl.clear  = 1'b1;
              ctrl.acc_en = (wl_q != '0);
              wr_addr     = '0;
              count_d     = CW'(1);
              pos_d       = '0;
            end
            brct_pkg::MODE_APPEND: begin
              if (count_q < CW'(RECORD_DEPTH)) begin
                ctrl.wr_en  = 1'b1;
                ctrl.acc_en = (XW'(count_q) < XW'(wl_q));
                count_d     = count_q + 1'b1;
              end
            end
            brct_pkg::MODE_DRAIN: begin
              if (pos_q < count_q) begin
                ctrl.rd_en      = 1'b1;
                ctrl.mean_start = (pos_q == '0) && (w_now > brct_pkg::WinW'(1));
                apply_d         = (w_now > brct_pkg::WinW'(1));
                taper_d         = apply_d && (XW'(pos_q) < XW'(w_now));
                taper_start     = taper_d;
                last_d          = ((pos_q + 1'b1) == count_q);
                pos_d           = pos_q + 1'b1;
                state_d         = brct_pkg::ST_WAIT;
              end
            end
            default: state_d = brct_pkg::ST_IDLE;
          endcase
        end
      end
      brct_pkg::ST_WAIT: begin
        if (!taper_busy && (lane_busy == '0)) begin
          state_d = brct_pkg::ST_DIFF;
        end
      end
      brct_pkg::ST_DIFF: begin
        ctrl.diff_en = 1'b1;
        state_d      = brct_pkg::ST_MUL;
      end
      brct_pkg::ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d     = brct_pkg::ST_EMIT;
      end
      brct_pkg::ST_EMIT: state_d = brct_pkg::ST_IDLE;
      default:           state_d = brct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brct_pkg::ST_IDLE;
      wl_q    <= '0;
      count_q <= '0;
      pos_q   <= '0;
      apply_q <= 1'b0;
      taper_q <= 1'b0;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      apply_q <= apply_d;
      taper_q <= taper_d;
      last_q  <= last_d;
      valid_q <= (state_q == brct_pkg::ST_EMIT);
      if (cfg_valid_i) begin
        wl_q <= cfg_data_i;
      end
    end
  end

  // Drain position of the transaction in flight.
  always_ff @(posedge clk_i) begin
    if (ctrl.rd_en) begin
      j_q <= pos_q;
    end
  end

  brct_taper u_taper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (taper_start),
    .j_i      (pos_wide[brct_pkg::WinW-1:0]),
    .w_i      (w_now),
    .busy_o   (taper_busy),
    .factor_o (taper_f)
  );

  for (genvar l = 0; l < NL; l++) begin : g_lane
    brct_lane #(
      .RECORD_DEPTH (RECORD_DEPTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_addr_i (wr_addr),
      .rd_addr_i (pos_q[AW-1:0]),
      .sample_i  (samples[l]),
      .w_i       (w_now),
      .factor_i  (lane_f),
      .busy_o    (lane_busy[l]),
      .result_o  (results[l])
    );
  end

  // Output register merging the lane results with the record position.
  always_ff @(posedge clk_i) begin
    if (state_q == brct_pkg::ST_EMIT) begin
      for (int l = 0; l < NL; l++) begin
        out_q[l] <= results[l];
      end
      idx_q      <= j_wide[brct_pkg::IdxW-1:0];
      out_last_q <= last_q;
    end
  end

  assign result_valid_o   = valid_q;
  assign radial_out_o     = out_q[0];
  assign transverse_out_o = out_q[1];
  assign third_out_o      = out_q[2];
  assign sample_index_o   = idx_q;
  assign last_flag_o      = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/core/brct_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module brct_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   rem_shift;
  logic             qbit;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    rem_shift = {rem_q, num_q[NUM_W-1]};
    qbit      = (rem_shift >= {1'b0, den_q});
    rem_d     = qbit ? DEN_W'(rem_shift - {1'b0, den_q}) : rem_shift[DEN_W-1:0];
    num_d     = {num_q[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      cnt_q  <= CntW'(NUM_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;

endmodule
`default_nettype wire

FILE: rtl/core/brct_taper.sv
// Raised-cosine taper factor: phase divide then a shared-multiplier sine polynomial.
`default_nettype none
module brct_taper (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [brct_pkg::WinW-1:0]     j_i,
  input  wire logic [brct_pkg::WinW-1:0]     w_i,
  output logic                               busy_o,
  output logic [brct_pkg::FactW-1:0]         factor_o
);

  brct_pkg::taper_state_e state_q, state_d;

  logic [brct_pkg::PhaseNumW-1:0] num;
  logic [brct_pkg::WinW-1:0]      den;
  logic                           div_busy;
  logic [brct_pkg::PhaseNumW-1:0] quot;
  logic                           div_start;

  logic [brct_pkg::QW-1:0]    x_q, x2_q, t_q, s_q;
  logic [brct_pkg::FactW-1:0] f_q;
  logic [brct_pkg::QW-1:0]    mul_a, mul_b, coef;
  logic [brct_pkg::MulW-1:0]  prod, fsum;
  logic [brct_pkg::FactW-1:0] u;
  logic [brct_pkg::QW-1:0]    prod_hi;
  logic [brct_pkg::MulW-1:30] s_full;

  // Phase u = round(j * 65536 / (w - 1)).
  assign den       = w_i - 1'b1;
  assign num       = {j_i, 16'd0} + brct_pkg::PhaseNumW'(den >> 1);
  assign div_start = start_i && (state_q == brct_pkg::T_IDLE);

  brct_div #(
    .NUM_W (brct_pkg::PhaseNumW),
    .DEN_W (brct_pkg::WinW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign u = (quot > brct_pkg::PhaseNumW'(brct_pkg::FactOne)) ? brct_pkg::FactOne
                                                               : quot[brct_pkg::FactW-1:0];

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = x2_q;
    mul_b = t_q;
    coef  = brct_pkg::CoefC7;
    case (state_q)
      brct_pkg::T_X2: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      brct_pkg::T_H7: coef = brct_pkg::CoefC7;
      brct_pkg::T_H5: coef = brct_pkg::CoefC5;
      brct_pkg::T_H3: coef = brct_pkg::CoefC3;
      brct_pkg::T_H1: coef = brct_pkg::CoefC1;
      brct_pkg::T_S: begin
        mul_a = x_q;
        mul_b = t_q;
      end
      brct_pkg::T_F: begin
        mul_a = s_q;
        mul_b = s_q;
      end
      default: coef = brct_pkg::CoefC7;
    endcase
  end

  assign prod    = brct_pkg::MulW'(mul_a) * brct_pkg::MulW'(mul_b);
  assign prod_hi = prod[60:30];
  assign s_full  = prod[brct_pkg::MulW-1:30];
  assign fsum    = prod + (brct_pkg::MulW'(1) << 43);

  // Step sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      brct_pkg::T_IDLE: if (start_i) state_d = brct_pkg::T_DIV;
      brct_pkg::T_DIV:  if (!div_busy) state_d = brct_pkg::T_X2;
      brct_pkg::T_X2:   state_d = brct_pkg::T_H7;
      brct_pkg::T_H7:   state_d = brct_pkg::T_H5;
      brct_pkg::T_H5:   state_d = brct_pkg::T_H3;
      brct_pkg::T_H3:   state_d = brct_pkg::T_H1;
      brct_pkg::T_H1:   state_d = brct_pkg::T_S;
      brct_pkg::T_S:    state_d = brct_pkg::T_F;
      brct_pkg::T_F:    state_d = brct_pkg::T_IDLE;
      default:          state_d = brct_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brct_pkg::T_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, one multiplication per step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      brct_pkg::T_DIV: x_q <= {u, 14'd0};
      brct_pkg::T_X2: begin
        x2_q <= prod_hi;
        t_q  <= brct_pkg::CoefC9;
      end
      brct_pkg::T_H7, brct_pkg::T_H5, brct_pkg::T_H3, brct_pkg::T_H1: begin
        t_q <= coef - prod_hi;
      end
      brct_pkg::T_S: begin
        s_q <= (s_full > 32'(brct_pkg::QOne)) ? brct_pkg::QOne : s_full[30+brct_pkg::QW-1:30];
      end
      brct_pkg::T_F: begin
        f_q <= (fsum[brct_pkg::MulW-1:44] > 18'(brct_pkg::FactOne)) ? brct_pkg::FactOne
                                                                     : fsum[60:44];
      end
      default: f_q <= f_q;
    endcase
  end

  assign busy_o   = (state_q != brct_pkg::T_IDLE);
  assign factor_o = f_q;

endmodule
`default_nettype wire

FILE: rtl/core/brct_lane.sv
// One channel lane: sample memory, window sum, mean divider and scaled output.
`default_nettype none
module brct_lane #(
  parameter int unsigned RECORD_DEPTH = 4096
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire brct_pkg::lane_ctrl_t                  ctrl_i,
  input  wire logic [$clog2(RECORD_DEPTH)-1:0]       wr_addr_i,
  input  wire logic [$clog2(RECORD_DEPTH)-1:0]       rd_addr_i,
  input  wire logic signed [brct_pkg::SampleW-1:0]   sample_i,
  input  wire logic [brct_pkg::WinW-1:0]             w_i,
  input  wire logic [brct_pkg::FactW-1:0]            factor_i,
  output logic                                       busy_o,
  output logic signed [brct_pkg::SampleW-1:0]        result_o
);

  localparam int unsigned SW = brct_pkg::SampleW;

  logic [SW-1:0] mem [RECORD_DEPTH];
  logic signed [SW-1:0]             rd_q;
  logic signed [brct_pkg::SumW-1:0] sum_q, sum_d;
  logic signed [brct_pkg::SumW-1:0] sum_mag;
  logic [brct_pkg::MeanNumW-1:0]    mean_num, quot;
  logic                             neg_q;
  logic signed [SW:0]               mean;
  logic signed [brct_pkg::DiffW-1:0] diff_q;
  logic signed [43:0]               prod_q;
  logic [43:0]                      prod_mag;
  logic [27:0]                      rq;
  logic signed [28:0]               rval;
  logic signed [SW-1:0]             sat;

  // Sample memory with registered read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= sample_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Running window sum.
  always_comb begin
    sum_d = ctrl_i.clear ? '0 : sum_q;
    if (ctrl_i.acc_en) begin
      sum_d = sum_d + brct_pkg::SumW'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        sum_q <= sum_d;
      end
      if (ctrl_i.mean_start) begin
        neg_q <= sum_q[brct_pkg::SumW-1];
      end
    end
  end

  // Rounded mean: divide the sum magnitude plus half the window by the window.
  assign sum_mag  = sum_q[brct_pkg::SumW-1] ? -sum_q : sum_q;
  assign mean_num = brct_pkg::MeanNumW'(sum_mag) + brct_pkg::MeanNumW'(w_i >> 1);

  brct_div #(
    .NUM_W (brct_pkg::MeanNumW),
    .DEN_W (brct_pkg::WinW)
  ) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.mean_start),
    .num_i   (mean_num),
    .den_i   (w_i),
    .busy_o  (busy_o),
    .quot_o  (quot)
  );

  assign mean = neg_q ? -$signed({1'b0, quot[SW-1:0]}) : $signed({1'b0, quot[SW-1:0]});

  // Baseline removal then taper scaling.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff_en) begin
      diff_q <= brct_pkg::DiffW'(rd_q) - brct_pkg::DiffW'(mean);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= 44'(diff_q) * $signed({1'b0, factor_i});
    end
  end

  // Round half away from zero by 2^16 and saturate.
  always_comb begin
    prod_mag = prod_q[43] ? 44'(-prod_q) : 44'(prod_q);
    rq       = 28'((prod_mag + 44'd32768) >> 16);
    rval     = prod_q[43] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    if (rval > 29'sd8388607) begin
      sat = 24'sh7FFFFF;
    end else if (rval < -29'sd8388608) begin
      sat = 24'sh800000;
    end else begin
      sat = rval[SW-1:0];
    end
  end

  assign result_o = ctrl_i.apply ? sat : rd_q;

endmodule
`default_nettype wire
